>>> hw/rtl/hrse_pkg.sv
// ----------------------------------------------------------------------------
// hrse_pkg
// Types, constants and the usage-to-scancode table for the boot-keyboard
// report to set-1 scancode event converter.
// ----------------------------------------------------------------------------
package hrse_pkg;

  localparam int MOD_EVENTS       = 6;
  localparam int INPUT_KEY_FIELDS = 6;
  localparam int USAGE_W          = 8;
  localparam int CODE_W           = 7;
  localparam logic [7:0] MIN_REPORT_LEN = 8'd8;

  typedef struct packed {
    logic              hit;
    logic              ext;
    logic [CODE_W-1:0] code;
  } key_map_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam logic [2:0] MOD_BIT [MOD_EVENTS] = '{
    3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6
  };

  localparam logic [CODE_W-1:0] MOD_CODE [MOD_EVENTS] = '{
    7'h1D, 7'h2A, 7'h38, 7'h1D, 7'h36, 7'h38
  };

  localparam logic MOD_EXT [MOD_EVENTS] = '{
    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1
  };

  localparam logic [CODE_W-1:0] LETTER_CODE [26] = '{
    7'h1E, 7'h30, 7'h2E, 7'h20, 7'h12, 7'h21, 7'h22, 7'h23, 7'h17, 7'h24,
    7'h25, 7'h26, 7'h32, 7'h31, 7'h18, 7'h19, 7'h10, 7'h13, 7'h1F, 7'h14,
    7'h16, 7'h2F, 7'h11, 7'h2D, 7'h15, 7'h2C
  };

  function automatic key_map_t map_usage(input logic [USAGE_W-1:0] u);
    key_map_t            m;
    logic [USAGE_W-1:0]  off;
    m   = '0;
    off = u - 8'h04;
    case (u) inside
      [8'h04:8'h1D]: begin
        m.hit  = 1'b1;
        m.code = LETTER_CODE[off[4:0]];
      end
      [8'h1E:8'h27]: begin
        off    = u - 8'h1C;
        m.hit  = 1'b1;
        m.code = off[CODE_W-1:0];
      end
      [8'h3A:8'h43]: begin
        off    = u + 8'h01;
        m.hit  = 1'b1;
        m.code = off[CODE_W-1:0];
      end
      8'h28: begin m.hit = 1'b1; m.code = 7'h1C; end
      8'h29: begin m.hit = 1'b1; m.code = 7'h01; end
      8'h2A: begin m.hit = 1'b1; m.code = 7'h0E; end
      8'h2B: begin m.hit = 1'b1; m.code = 7'h0F; end
      8'h2C: begin m.hit = 1'b1; m.code = 7'h39; end
      8'h2D: begin m.hit = 1'b1; m.code = 7'h0C; end
      8'h2E: begin m.hit = 1'b1; m.code = 7'h0D; end
      8'h2F: begin m.hit = 1'b1; m.code = 7'h1A; end
      8'h30: begin m.hit = 1'b1; m.code = 7'h1B; end
      8'h31: begin m.hit = 1'b1; m.code = 7'h2B; end
      8'h33: begin m.hit = 1'b1; m.code = 7'h27; end
      8'h34: begin m.hit = 1'b1; m.code = 7'h28; end
      8'h35: begin m.hit = 1'b1; m.code = 7'h29; end
      8'h36: begin m.hit = 1'b1; m.code = 7'h33; end
      8'h37: begin m.hit = 1'b1; m.code = 7'h34; end
      8'h38: begin m.hit = 1'b1; m.code = 7'h35; end
      8'h39: begin m.hit = 1'b1; m.code = 7'h3A; end
      8'h44: begin m.hit = 1'b1; m.code = 7'h57; end
      8'h45: begin m.hit = 1'b1; m.code = 7'h58; end
      8'h4F: begin m.hit = 1'b1; m.ext = 1'b1; m.code = 7'h4D; end
      8'h50: begin m.hit = 1'b1; m.ext = 1'b1; m.code = 7'h4B; end
      8'h51: begin m.hit = 1'b1; m.ext = 1'b1; m.code = 7'h50; end
      8'h52: begin m.hit = 1'b1; m.ext = 1'b1; m.code = 7'h48; end
      default: ;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/hrse_fifo.sv
// ----------------------------------------------------------------------------
// hrse_fifo
// Short register queue between the report classifier and the event emitter.
// ----------------------------------------------------------------------------
module hrse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   pop,
  output logic [WIDTH-1:0]       rdata,
  output hrse_pkg::queue_status_t status
);
  import hrse_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata        = mem[rd_ptr];
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

endmodule

>>> hw/rtl/hrse_front.sv
// ----------------------------------------------------------------------------
// hrse_front
// Accepts reports, compares them with the held state and queues a mask of
// the events to emit together with the usages they refer to.
// ----------------------------------------------------------------------------
module hrse_front #(
  parameter int KEY_SLOTS = 6,
  parameter int ENTRY_W   = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [63:0]             s_tdata,
  input  hrse_pkg::queue_status_t q_status,
  output logic                    push,
  output logic [ENTRY_W-1:0]      entry
);
  import hrse_pkg::*;

  localparam int EW = MOD_EVENTS + 2 * KEY_SLOTS;

  logic [7:0]         held_mods;
  logic [USAGE_W-1:0] held_keys [KEY_SLOTS];
  logic [USAGE_W-1:0] now_keys  [KEY_SLOTS];
  logic [7:0]         mods;
  logic [7:0]         rpt_len;
  logic [EW-1:0]      mask;
  logic               accept;
  logic               rpt_ok;

  assign mods    = s_tdata[7:0];
  assign rpt_len = s_tdata[63:56];

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_now
    if (i < INPUT_KEY_FIELDS) begin : g_in
      assign now_keys[i] = s_tdata[8*(i+1) +: 8];
    end else begin : g_pad
      assign now_keys[i] = '0;
    end
  end

  always_comb begin
    logic in_now;
    logic in_held;
    key_map_t mo;
    key_map_t mn;
    mask = '0;
    for (int m = 0; m < MOD_EVENTS; m++) begin
      mask[m] = held_mods[MOD_BIT[m]] ^ mods[MOD_BIT[m]];
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      in_now  = 1'b0;
      in_held = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        in_now  = in_now  | (held_keys[i] == now_keys[j]);
        in_held = in_held | (now_keys[i] == held_keys[j]);
      end
      mo = map_usage(held_keys[i]);
      mn = map_usage(now_keys[i]);
      mask[MOD_EVENTS + i] = (held_keys[i] != '0) && !in_now && mo.hit;
      mask[MOD_EVENTS + KEY_SLOTS + i] = (now_keys[i] != '0) && !in_held && mn.hit;
    end
  end

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_pack
    assign entry[EW + 8 + USAGE_W*i +: USAGE_W]                     = held_keys[i];
    assign entry[EW + 8 + USAGE_W*(KEY_SLOTS + i) +: USAGE_W]       = now_keys[i];
  end
  assign entry[EW-1:0]    = mask;
  assign entry[EW +: 8]   = mods;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;
  assign rpt_ok   = (rpt_len >= MIN_REPORT_LEN);
  assign push     = accept && rpt_ok && (mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mods <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        held_keys[i] <= '0;
      end
    end else if (accept && rpt_ok) begin
      held_mods <= mods;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        held_keys[i] <= now_keys[i];
      end
    end
  end

endmodule

>>> hw/rtl/hrse_back.sv
// ----------------------------------------------------------------------------
// hrse_back
// Walks the queued event mask lowest bit first and emits one scancode event
// per cycle into the output register while events are queued and the output is not stalled.
// ----------------------------------------------------------------------------
module hrse_back #(
  parameter int KEY_SLOTS = 6,
  parameter int ENTRY_W   = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  hrse_pkg::queue_status_t q_status,
  input  logic [ENTRY_W-1:0]      head,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [7:0]              m_tdata,
  output logic [1:0]              m_tuser,
  output logic                    m_tlast
);
  import hrse_pkg::*;

  localparam int EW = MOD_EVENTS + 2 * KEY_SLOTS;
  localparam int IW = $clog2(EW);

  logic [EW-1:0]      done;
  logic [EW-1:0]      pending;
  logic [EW-1:0]      low;
  logic [IW-1:0]      sel;
  logic [7:0]         mods;
  logic [USAGE_W-1:0] ev_usage [EW];
  logic               last;
  logic               fire;
  logic               is_mod;
  logic               is_make;
  key_map_t           km;
  logic [CODE_W-1:0]  code;
  logic               ext;
  logic               press;

  assign mods    = head[EW +: 8];
  assign pending = head[EW-1:0] & ~done;
  assign low     = pending & (~pending + 1'b1);
  assign last    = ((pending & ~low) == '0);

  for (genvar j = 0; j < EW; j++) begin : g_usage
    if (j < MOD_EVENTS) begin : g_mod
      assign ev_usage[j] = '0;
    end else begin : g_key
      assign ev_usage[j] = head[EW + 8 + USAGE_W*(j - MOD_EVENTS) +: USAGE_W];
    end
  end

  always_comb begin
    sel = '0;
    for (int j = 0; j < EW; j++) begin
      if (low[j]) begin
        sel = sel | IW'(j);
      end
    end
  end

  assign is_mod  = (sel < IW'(MOD_EVENTS));
  assign is_make = (sel >= IW'(MOD_EVENTS + KEY_SLOTS));
  assign km      = map_usage(ev_usage[sel]);

  always_comb begin
    if (is_mod) begin
      code  = MOD_CODE[sel[2:0]];
      ext   = MOD_EXT[sel[2:0]];
      press = mods[MOD_BIT[sel[2:0]]];
    end else begin
      code  = km.code;
      ext   = km.ext;
      press = is_make;
    end
  end

  assign fire = !q_status.empty && (!m_tvalid || m_tready);
  assign pop  = fire && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        done     <= last ? '0 : (done | low);
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {1'b0, code};
      m_tuser <= {press, ext};
      m_tlast <= last;
    end
  end

`ifndef SYNTHESIS
  a_pending_nonzero: assert property (@(posedge clk) disable iff (rst)
    !q_status.empty |-> (pending != '0))
    else $error("queued request has no event left");

  a_done_clear: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> (done == '0))
    else $error("event progress kept with empty queue");

  a_head_kept: assert property (@(posedge clk) disable iff (rst)
    fire && !last |=> !q_status.empty)
    else $error("request left the queue before its last event");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");
`endif

endmodule

>>> hw/rtl/hid_report_to_scancode_events_core.sv
// ----------------------------------------------------------------------------
// hid_report_to_scancode_events_core
// Path: an accepted request goes into the queue, and its first event then
// passes through the output register to m_*. Throughput: one event per
// cycle unless m_tready stalls the output; a new request is taken while
// the queue has room. Requests that cause no event never enter the queue.
// Reset: rst clears the held modifiers and keys, the queue and the output.
// ----------------------------------------------------------------------------
module hid_report_to_scancode_events_core #(
  parameter int KEY_SLOTS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // modifier_bits, key_slot_0 .. key_slot_5, report_length
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // scan_code, zero pad
  output logic [7:0]  m_tdata,
  // extended_key, key_pressed
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);
  import hrse_pkg::*;

  localparam int EW      = MOD_EVENTS + 2 * KEY_SLOTS;
  localparam int ENTRY_W = EW + 8 + 2 * KEY_SLOTS * USAGE_W;

  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] head;
  queue_status_t      q_status;

  hrse_front #(
    .KEY_SLOTS (KEY_SLOTS),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_status (q_status),
    .push     (push),
    .entry    (entry)
  );

  hrse_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (entry),
    .pop    (pop),
    .rdata  (head),
    .status (q_status)
  );

  hrse_back #(
    .KEY_SLOTS (KEY_SLOTS),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
